FILE: hdl/lcf_pkg.sv
`default_nettype none

package lcf_pkg;

   // Defaults for the top-level parameters.
   localparam int TAPS_MAX_DEF    = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed field widths.
   localparam int COEF_BITS      = 16;
   localparam int INDEX_BITS     = 5;
   localparam int TAP_COUNT_BITS = 6;
   localparam int Y_BITS         = 37;
   localparam int RSP_DATA_W     = ((Y_BITS + 7) / 8) * 8;

   // Bit positions of the request fields inside req_tdata.
   localparam int INDEX_LSB  = 0;
   localparam int COEF_LSB   = INDEX_LSB + INDEX_BITS;
   localparam int SAMPLE_LSB = COEF_LSB + COEF_BITS;

   localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 6'd32;

   // Request kinds carried on req_tuser.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef logic signed [Y_BITS-1:0] acc_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/lcf_cell.sv
`default_nettype none

// One tap of the filter: a delay-line stage, its coefficient, a registered
// product and one stage of the running sum that ripples down the row.
module lcf_cell
   import lcf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cell_ctrl_type                 ctrl,
   input  wire logic                          coef_we,
   input  wire logic signed [COEF_BITS-1:0]   coef_value,
   input  wire logic signed [SAMPLE_BITS-1:0] x_prev,
   input  wire acc_type                       sum_prev,
   output logic signed [SAMPLE_BITS-1:0]      x_next,
   output acc_type                            sum_next
);

   localparam int ProdW = SAMPLE_BITS + COEF_BITS;

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [COEF_BITS-1:0]   h_ff, h_in;
   logic signed [ProdW-1:0]       prod_ff, prod_in;
   acc_type                       sum_ff, sum_in;

   always_comb begin
      x_in = x_ff;
      if (ctrl.clear) begin
         x_in = '0;
      end else if (ctrl.shift) begin
         x_in = x_prev;
      end
      h_in    = coef_we ? coef_value : h_ff;
      prod_in = x_ff * h_ff;
      sum_in  = sum_prev + Y_BITS'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         h_ff <= '0;
      end else begin
         x_ff <= x_in;
         h_ff <= h_in;
      end
   end

   // The sum stage runs freely; it is read only once the row has settled.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign x_next   = x_ff;
   assign sum_next = sum_ff;

endmodule

`default_nettype wire

FILE: hdl/linear_convolution_fir.sv
// Direct-form FIR filter giving the full linear convolution of a sample
// stream with a loaded impulse response, in signed Q1.15 fixed point.
// Request channel (req_*): req_tuser selects a coefficient load or a sample.
// A load writes one tap and gives no result. A sample gives one output; a
// sample with req_tlast also gives one tail output less than the taps in use,
// the last one marked with rsp_tlast, after which the delay line is cleared.
// Result channel (rsp_*): the 37-bit Q7.30 sum, exact, no saturation.
// Timing: loads are taken back to back. Each output waits for the delay
// line to shift, for the tap products to be registered and for the
// partial sum to ripple down the row of tap cells; no new request is
// taken meanwhile. Once a sample's last output is written, the next
// request can be taken in the cycle after.
// The output register holds one finished result; if the receiver stalls,
// the block still takes the next request and waits before its own output
// until that register is free.
// Reset clears the delay line and the taps and sets tap_count to 32.
// csr_wr_en writes tap_count; do so only while the block is idle.
`default_nettype none

module linear_convolution_fir
   import lcf_pkg::*;
#(
   parameter  int TAPS_MAX    = TAPS_MAX_DEF,
   parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int ReqDataW    = ((SAMPLE_LSB + SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Request channel.
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // req_tdata from bit 0 up: coef_index, coef_value, sample, zero padding.
   input  wire logic [ReqDataW-1:0]       req_tdata,
   // req_tuser: req_type (0 = coefficient load, 1 = sample).
   input  wire logic                      req_tuser,
   input  wire logic                      req_tlast,
   // Result channel.
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // rsp_tdata from bit 0 up: y, zero padding.
   output logic [RSP_DATA_W-1:0]          rsp_tdata,
   output logic                           rsp_tlast,
   // Tap count register.
   input  wire logic                      csr_wr_en,
   input  wire logic [TAP_COUNT_BITS-1:0] csr_wr_data
);

   localparam int TapCntW = $clog2(TAPS_MAX + 1);
   localparam int CntW    = $clog2(TAPS_MAX + 2);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_CALC = 1'b1;

   // Request fields.
   logic        [INDEX_BITS-1:0]  coef_index;
   logic signed [COEF_BITS-1:0]   coef_value;
   logic signed [SAMPLE_BITS-1:0] sample;

   assign coef_index = req_tdata[INDEX_LSB +: INDEX_BITS];
   assign coef_value = req_tdata[COEF_LSB +: COEF_BITS];
   assign sample     = req_tdata[SAMPLE_LSB +: SAMPLE_BITS];

   // Sequencer and configuration state.
   logic                      state_ff, state_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic [TapCntW-1:0]        tail_ff, tail_in;
   logic                      last_ff, last_in;
   logic [TAP_COUNT_BITS-1:0] tap_count_ff, tap_count_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   acc_type                   rsp_y_ff, rsp_y_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      accept;
   logic                      load_xfer;
   logic                      sample_xfer;
   logic [TapCntW-1:0]        taps;
   logic                      settled;
   logic                      out_free;
   logic                      emit;
   cell_ctrl_type             cell_ctrl;
   logic signed [SAMPLE_BITS-1:0] x_chain [TAPS_MAX+1];
   acc_type                   sum_chain [TAPS_MAX+1];

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign load_xfer   = accept && (req_tuser == REQ_LOAD);
   assign sample_xfer = accept && (req_tuser == REQ_SAMPLE);

   // Taps in use: zero counts as one, anything past the row is the whole row.
   always_comb begin
      if (tap_count_ff == '0) begin
         taps = TapCntW'(1);
      end else if (32'(tap_count_ff) > TAPS_MAX) begin
         taps = TapCntW'(TAPS_MAX);
      end else begin
         taps = TapCntW'(tap_count_ff);
      end
   end

   // After a shift the products are registered, then the sum ripples down the row.
   assign settled  = (cnt_ff > CntW'(taps));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = (state_ff == ST_CALC) && settled && out_free;

   // A tail output shifts a zero in; the final output of a signal clears
   // the delay line.
   assign cell_ctrl.shift = sample_xfer || (emit && (tail_ff != '0));
   assign cell_ctrl.clear = emit && (tail_ff == '0) && last_ff;

   assign x_chain[0]   = sample_xfer ? sample : '0;
   assign sum_chain[0] = '0;

   for (genvar k = 0; k < TAPS_MAX; k++) begin : g_cell
      lcf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .coef_we    (load_xfer && (32'(coef_index) == k)),
         .coef_value (coef_value),
         .x_prev     (x_chain[k]),
         .sum_prev   (sum_chain[k]),
         .x_next     (x_chain[k+1]),
         .sum_next   (sum_chain[k+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tail_in      = tail_ff;
      last_in      = last_ff;
      tap_count_in = csr_wr_en ? csr_wr_data : tap_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (sample_xfer) begin
               state_in = ST_CALC;
               cnt_in   = '0;
               tail_in  = req_tlast ? taps - TapCntW'(1) : '0;
               last_in  = req_tlast;
            end
         end
         ST_CALC: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_y_in     = sum_chain[taps];
               rsp_last_in  = last_ff && (tail_ff == '0);
               if (tail_ff != '0) begin
                  tail_in = tail_ff - TapCntW'(1);
                  cnt_in  = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!settled) begin
               cnt_in = cnt_ff + CntW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         last_ff      <= 1'b0;
         tap_count_ff <= TAP_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         last_ff      <= last_in;
         tap_count_ff <= tap_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - Y_BITS){1'b0}}, rsp_y_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A shift and a clear of the delay line never coincide.
   assert property (@(posedge clock) disable iff (reset)
      !(cell_ctrl.shift && cell_ctrl.clear))
      else $error("delay line shifted and cleared in the same cycle");

   // Clearing the delay line goes with the output that ends a signal.
   assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.clear |=> rsp_tvalid && rsp_tlast)
      else $error("delay line cleared without a final output");

   // A tail output restarts the settling count for the next one.
   assert property (@(posedge clock) disable iff (reset)
      emit && (tail_ff != '0) |=> (state_ff == ST_CALC) && (cnt_ff == '0))
      else $error("tail output did not start the next sum");

   // No tail outputs remain pending once the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (tail_ff == '0))
      else $error("idle with tail outputs pending");

   // A result is never written over one that has not been taken.
   assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_tready)
      else $error("output register overwritten");

endmodule

`default_nettype wire
